// ----- rtl/core/gcsm_pkg.sv -----
// ----------------------------------------------------------------------------
// gcsm_pkg - shared types and constants of the caliper score matcher
// Item layouts, configuration register indexes, reset values and the
// controller state encoding.
// ----------------------------------------------------------------------------
`default_nettype none

package gcsm_pkg;

  // default sizes of the control table and of the match list
  localparam int DEF_MAX_CONTROLS = 1024;
  localparam int DEF_MAX_MATCH    = 8;
  // no case ever produces more results than this
  localparam int RESULT_LIMIT     = 8;

  // field widths
  localparam int SCORE_W = 16;
  localparam int SLOT_W  = 10;
  localparam int TAG_W   = 16;
  localparam int MC_W    = 4;
  localparam int CC_W    = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MATCH_COUNT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CONTROL_COUNT = 2'd2;

  // register reset values (threshold 0.1 in Q0.16)
  localparam logic [SCORE_W-1:0] THRESHOLD_RST     = 16'd6554;
  localparam logic [MC_W-1:0]    MATCH_COUNT_RST   = 4'd1;
  localparam logic [CC_W-1:0]    CONTROL_COUNT_RST = 11'd0;

  // operation codes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_CASE = 1'b1;

  typedef struct packed {
    logic               opcode;
    logic [SCORE_W-1:0] score;
    logic [SLOT_W-1:0]  slot;
    logic [TAG_W-1:0]   case_tag;
  } in_item_t;

  typedef struct packed {
    logic [TAG_W-1:0]  tag_out;
    logic [SLOT_W-1:0] control_index;
    logic              matched;
    logic              last;
  } out_item_t;

  // control of the best-candidate list
  typedef struct packed {
    logic clr;
    logic ins;
    logic pop;
  } list_ctl_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_EMIT,
    ST_FAIL
  } state_t;

endpackage

`default_nettype wire

// ----- rtl/core/greedy_caliper_score_matcher.sv -----
// ----------------------------------------------------------------------------
// greedy_caliper_score_matcher - greedy caliper matching without replacement
// Load: accepted while idle, busy stays low. Case: busy through a table scan
// (one entry per cycle through the score and taken memories; no reads when
// the pool is empty, counts above MAX_CONTROLS scan the whole table), then
// through the results, issued back to back; each result is registered and
// strobes for one cycle. After reset the taken flags are cleared, one entry a
// cycle, busy high throughout. Results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
`default_nettype none

module greedy_caliper_score_matcher #(
  parameter int MAX_CONTROLS = gcsm_pkg::DEF_MAX_CONTROLS,
  parameter int MAX_MATCH    = gcsm_pkg::DEF_MAX_MATCH
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // commands
  input  wire logic                            start,
  output logic                                 busy,
  input  wire gcsm_pkg::in_item_t              in_item,
  // results
  output logic                                 out_valid,
  output gcsm_pkg::out_item_t                  out_item,
  // configuration
  input  wire logic                            cfg_we,
  input  wire logic [gcsm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [gcsm_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int AW   = (MAX_CONTROLS > 1) ? $clog2(MAX_CONTROLS) : 1;
  localparam int CW   = $clog2(MAX_CONTROLS + 1);
  localparam int LIST = (MAX_MATCH < gcsm_pkg::RESULT_LIMIT) ? MAX_MATCH
                                                             : gcsm_pkg::RESULT_LIMIT;
  localparam int NW   = $clog2(LIST + 1);
  localparam int SW   = gcsm_pkg::SCORE_W;

  gcsm_pkg::state_t state_r, state_nxt;

  // configuration registers
  logic [SW-1:0]              threshold_r;
  logic [gcsm_pkg::MC_W-1:0]  match_count_r;
  logic [gcsm_pkg::CC_W-1:0]  control_count_r;

  // per-case registers
  logic [SW-1:0]              score_r, score_nxt;
  logic [gcsm_pkg::TAG_W-1:0] tag_r, tag_nxt;
  logic [NW-1:0]              need_r, need_nxt;
  logic [CW-1:0]              n_r, n_nxt;
  logic [CW-1:0]              j_r, j_nxt;
  logic                       pv_r, pv_nxt;
  logic [AW-1:0]              pidx_r, pidx_nxt;
  logic [AW-1:0]              clr_addr_r, clr_addr_nxt;

  // result register
  logic                       out_valid_r, out_valid_nxt;
  gcsm_pkg::out_item_t        out_item_r, out_item_nxt;

  // memories
  logic                       score_we;
  logic [AW-1:0]              score_waddr;
  logic [SW-1:0]              score_rdata;
  logic                       taken_we;
  logic [AW-1:0]              taken_waddr;
  logic [0:0]                 taken_wdata;
  logic [0:0]                 taken_rdata;
  logic [AW-1:0]              rd_addr;

  // list
  gcsm_pkg::list_ctl_t        list_ctl;
  logic [AW-1:0]              head_idx;
  logic [NW-1:0]              list_count;

  logic                       accept;
  logic                       load_ok;
  logic [SW-1:0]              diff;
  logic [NW-1:0]              need_clamped;
  logic [CW-1:0]              n_clamped;

  assign busy    = (state_r != gcsm_pkg::ST_IDLE);
  assign accept  = start && !busy;
  assign load_ok = accept && (in_item.opcode == gcsm_pkg::OP_LOAD)
                   && (32'(in_item.slot) < 32'(MAX_CONTROLS));

  // absolute score difference of the entry just read
  assign diff = (score_rdata >= score_r) ? score_rdata - score_r : score_r - score_rdata;

  // clamp match count to 1..LIST and control count to the table size
  always_comb begin
    if (match_count_r == '0) begin
      need_clamped = NW'(1);
    end else if (32'(match_count_r) > 32'(LIST)) begin
      need_clamped = NW'(LIST);
    end else begin
      need_clamped = NW'(match_count_r);
    end
    if (32'(control_count_r) > 32'(MAX_CONTROLS)) begin
      n_clamped = CW'(MAX_CONTROLS);
    end else begin
      n_clamped = CW'(control_count_r);
    end
  end

  // score table
  gcsm_ram #(
    .WIDTH (SW),
    .DEPTH (MAX_CONTROLS),
    .AW    (AW)
  ) u_score_ram (
    .clk   (clk),
    .we    (score_we),
    .waddr (score_waddr),
    .wdata (in_item.score),
    .raddr (rd_addr),
    .rdata (score_rdata)
  );

  // taken flags
  gcsm_ram #(
    .WIDTH (1),
    .DEPTH (MAX_CONTROLS),
    .AW    (AW)
  ) u_taken_ram (
    .clk   (clk),
    .we    (taken_we),
    .waddr (taken_waddr),
    .wdata (taken_wdata),
    .raddr (rd_addr),
    .rdata (taken_rdata)
  );

  // closest candidates
  gcsm_best_list #(
    .DEPTH (LIST),
    .IW    (AW),
    .NW    (NW)
  ) u_best_list (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (list_ctl),
    .need     (need_r),
    .d_in     (diff),
    .idx_in   (pidx_r),
    .head_idx (head_idx),
    .count    (list_count)
  );

  // controller: next state, memory accesses and results
  always_comb begin
    state_nxt     = state_r;
    score_nxt     = score_r;
    tag_nxt       = tag_r;
    need_nxt      = need_r;
    n_nxt         = n_r;
    j_nxt         = j_r;
    pv_nxt        = pv_r;
    pidx_nxt      = pidx_r;
    clr_addr_nxt  = clr_addr_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    list_ctl      = '0;
    rd_addr       = j_r[AW-1:0];
    score_we      = load_ok;
    score_waddr   = AW'(in_item.slot);
    taken_we      = load_ok;
    taken_waddr   = AW'(in_item.slot);
    taken_wdata   = 1'b0;

    unique case (state_r)
      gcsm_pkg::ST_CLEAR: begin
        // sweep the taken flags to zero
        taken_we     = 1'b1;
        taken_waddr  = clr_addr_r;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == AW'(MAX_CONTROLS - 1)) begin
          state_nxt = gcsm_pkg::ST_IDLE;
        end
      end

      gcsm_pkg::ST_IDLE: begin
        // a case starts a scan from entry zero
        if (accept && (in_item.opcode == gcsm_pkg::OP_CASE)) begin
          score_nxt    = in_item.score;
          tag_nxt      = in_item.case_tag;
          need_nxt     = need_clamped;
          n_nxt        = n_clamped;
          j_nxt        = '0;
          pv_nxt       = 1'b0;
          list_ctl.clr = 1'b1;
          state_nxt    = gcsm_pkg::ST_SCAN;
        end
      end

      gcsm_pkg::ST_SCAN: begin
        // issue the next read, rank the entry read last cycle
        if (j_r < n_r) begin
          j_nxt    = j_r + 1'b1;
          pv_nxt   = 1'b1;
          pidx_nxt = j_r[AW-1:0];
        end else begin
          pv_nxt = 1'b0;
        end
        list_ctl.ins = pv_r && (taken_rdata == 1'b0) && (diff <= threshold_r);
        if ((j_r == n_r) && !pv_r) begin
          state_nxt = (list_count == need_r) ? gcsm_pkg::ST_EMIT : gcsm_pkg::ST_FAIL;
        end
      end

      gcsm_pkg::ST_EMIT: begin
        // one assignment per cycle, closest first
        taken_we                   = 1'b1;
        taken_waddr                = head_idx;
        taken_wdata                = 1'b1;
        list_ctl.pop               = 1'b1;
        out_valid_nxt              = 1'b1;
        out_item_nxt.tag_out       = tag_r;
        out_item_nxt.control_index = gcsm_pkg::SLOT_W'(head_idx);
        out_item_nxt.matched       = 1'b1;
        out_item_nxt.last          = (list_count == NW'(1));
        if (list_count == NW'(1)) begin
          state_nxt = gcsm_pkg::ST_IDLE;
        end
      end

      gcsm_pkg::ST_FAIL: begin
        // too few controls in the caliper
        out_valid_nxt              = 1'b1;
        out_item_nxt.tag_out       = tag_r;
        out_item_nxt.control_index = '0;
        out_item_nxt.matched       = 1'b0;
        out_item_nxt.last          = 1'b1;
        state_nxt                  = gcsm_pkg::ST_IDLE;
      end

      default: begin
        state_nxt = gcsm_pkg::ST_IDLE;
      end
    endcase
  end

  // state and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gcsm_pkg::ST_CLEAR;
      clr_addr_r  <= '0;
      j_r         <= '0;
      pv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      j_r         <= j_nxt;
      pv_r        <= pv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // per-case payload registers
  always_ff @(posedge clk) begin
    score_r    <= score_nxt;
    tag_r      <= tag_nxt;
    need_r     <= need_nxt;
    n_r        <= n_nxt;
    pidx_r     <= pidx_nxt;
    out_item_r <= out_item_nxt;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r     <= gcsm_pkg::THRESHOLD_RST;
      match_count_r   <= gcsm_pkg::MATCH_COUNT_RST;
      control_count_r <= gcsm_pkg::CONTROL_COUNT_RST;
    end else if (cfg_we) begin
      if (cfg_index == gcsm_pkg::REG_THRESHOLD) begin
        threshold_r <= cfg_wdata;
      end
      if (cfg_index == gcsm_pkg::REG_MATCH_COUNT) begin
        match_count_r <= cfg_wdata[gcsm_pkg::MC_W-1:0];
      end
      if (cfg_index == gcsm_pkg::REG_CONTROL_COUNT) begin
        control_count_r <= cfg_wdata[gcsm_pkg::CC_W-1:0];
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

// ----- rtl/core/gcsm_ram.sv -----
// ----------------------------------------------------------------------------
// gcsm_ram - generic single-port-write, single-port-read memory
// One write and one read per cycle, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module gcsm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/core/gcsm_best_list.sv -----
// ----------------------------------------------------------------------------
// gcsm_best_list - sorted list of the closest qualifying controls
// Keeps up to need entries ordered by score difference, equal differences
// in arrival order; one insertion or one removal from the head per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module gcsm_best_list #(
  parameter int DEPTH = 8,
  parameter int IW    = 10,
  parameter int NW    = $clog2(DEPTH + 1)
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire gcsm_pkg::list_ctl_t          ctl,
  input  wire logic [NW-1:0]                need,
  input  wire logic [gcsm_pkg::SCORE_W-1:0] d_in,
  input  wire logic [IW-1:0]                idx_in,
  output logic      [IW-1:0]                head_idx,
  output logic      [NW-1:0]                count
);

  logic [gcsm_pkg::SCORE_W-1:0] d_r   [DEPTH];
  logic [gcsm_pkg::SCORE_W-1:0] d_nxt [DEPTH];
  logic [IW-1:0]                idx_r   [DEPTH];
  logic [IW-1:0]                idx_nxt [DEPTH];
  logic [NW-1:0]                count_r, count_nxt;
  logic [DEPTH-1:0]             le;
  logic [DEPTH-1:0]             prev_le;
  logic                         fits;

  // entries that stay ahead of the new candidate (prefix of the list)
  always_comb begin
    for (int k = 0; k < DEPTH; k++) begin
      le[k] = (NW'(k) < count_r) && (d_r[k] <= d_in);
    end
    prev_le[0] = 1'b1;
    for (int k = 1; k < DEPTH; k++) begin
      prev_le[k] = le[k-1];
    end
    // candidate lands inside the first need places
    fits = 1'b0;
    for (int k = 0; k < DEPTH; k++) begin
      if ((NW'(k) < need) && !le[k]) begin
        fits = 1'b1;
      end
    end
  end

  // next list contents
  always_comb begin
    d_nxt     = d_r;
    idx_nxt   = idx_r;
    count_nxt = count_r;
    priority if (ctl.clr) begin
      count_nxt = '0;
    end else if (ctl.pop) begin
      for (int k = 0; k < DEPTH - 1; k++) begin
        d_nxt[k]   = d_r[k+1];
        idx_nxt[k] = idx_r[k+1];
      end
      count_nxt = count_r - 1'b1;
    end else if (ctl.ins && fits) begin
      for (int k = 0; k < DEPTH; k++) begin
        if (le[k]) begin
          d_nxt[k]   = d_r[k];
          idx_nxt[k] = idx_r[k];
        end else if (prev_le[k]) begin
          d_nxt[k]   = d_in;
          idx_nxt[k] = idx_in;
        end else begin
          d_nxt[k]   = d_r[(k > 0) ? k - 1 : 0];
          idx_nxt[k] = idx_r[(k > 0) ? k - 1 : 0];
        end
      end
      count_nxt = (count_r < need) ? count_r + 1'b1 : count_r;
    end else begin
      count_nxt = count_r;
    end
  end

  // fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // list entries
  always_ff @(posedge clk) begin
    d_r   <= d_nxt;
    idx_r <= idx_nxt;
  end

  assign head_idx = idx_r[0];
  assign count    = count_r;

endmodule

`default_nettype wire

// ----- test/gcsm_match_checker.sv -----
// ----------------------------------------------------------------------------
// gcsm_match_checker - scoreboard for the caliper score matcher
// Watches the command, result and register ports, keeps its own copy of the
// control table and taken flags, works out the assignments of every case
// transfer and compares each result transfer with the oldest one due.
// ----------------------------------------------------------------------------
`default_nettype none

module gcsm_match_checker (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  input  wire logic                            busy,
  input  wire gcsm_pkg::in_item_t              in_item,
  input  wire logic                            out_valid,
  input  wire gcsm_pkg::out_item_t             out_item,
  input  wire logic                            cfg_we,
  input  wire logic [gcsm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [gcsm_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int unsigned                          mismatch_count,
  output int unsigned                          awaited_results
);
  timeunit 1ns;
  timeprecision 1ps;

  // mirrored registers and table
  logic [gcsm_pkg::SCORE_W-1:0] caliper;
  logic [gcsm_pkg::MC_W-1:0]    pick_count;
  logic [gcsm_pkg::CC_W-1:0]    pool_size;
  logic [gcsm_pkg::SCORE_W-1:0] ctrl_score [gcsm_pkg::DEF_MAX_CONTROLS];
  bit                           ctrl_taken [gcsm_pkg::DEF_MAX_CONTROLS];

  // assignments still to come out, oldest first
  gcsm_pkg::out_item_t assignments_due [$];
  gcsm_pkg::out_item_t want;

  task automatic report_bad(input string what, input gcsm_pkg::out_item_t exp_item,
                            input gcsm_pkg::out_item_t got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t %s: expected %h/%0d/%b/%b got %h/%0d/%b/%b",
               $time, what, exp_item.tag_out, exp_item.control_index, exp_item.matched,
               exp_item.last, got.tag_out, got.control_index, got.matched, got.last);
  endtask

  // greedy nearest-neighbour pick of one case
  task automatic match_case(input logic [gcsm_pkg::SCORE_W-1:0] probe,
                            input logic [gcsm_pkg::TAG_W-1:0] tag);
    int unsigned limit, need, found, kept, pos, k, j, delta;
    int unsigned best_idx  [gcsm_pkg::RESULT_LIMIT];
    int unsigned best_dist [gcsm_pkg::RESULT_LIMIT];
    gcsm_pkg::out_item_t res;
    limit = (pool_size > gcsm_pkg::DEF_MAX_CONTROLS) ? gcsm_pkg::DEF_MAX_CONTROLS
                                                     : pool_size;
    need  = (pick_count == 0) ? 1 : pick_count;
    if (need > gcsm_pkg::DEF_MAX_MATCH) need = gcsm_pkg::DEF_MAX_MATCH;
    if (need > gcsm_pkg::RESULT_LIMIT) need = gcsm_pkg::RESULT_LIMIT;
    found = 0;
    kept  = 0;
    for (j = 0; j < limit; j++) begin
      if (ctrl_score[j] >= probe) delta = ctrl_score[j] - probe;
      else delta = probe - ctrl_score[j];
      if (!ctrl_taken[j] && delta <= caliper) begin
        found++;
        // sorted insert, equal distances stay behind earlier indexes
        if (kept < need || delta < best_dist[need-1]) begin
          pos = kept;
          while (pos > 0 && best_dist[pos-1] > delta) pos--;
          k = (kept < need) ? kept : need - 1;
          while (k > pos) begin
            best_dist[k] = best_dist[k-1];
            best_idx[k]  = best_idx[k-1];
            k--;
          end
          best_dist[pos] = delta;
          best_idx[pos]  = j;
          if (kept < need) kept++;
        end
      end
    end
    res.tag_out = tag;
    if (found < need) begin
      // too few controls in the caliper: one refusal, nothing marked
      res.control_index = '0;
      res.matched       = 1'b0;
      res.last          = 1'b1;
      assignments_due   = {assignments_due, res};
    end else begin
      for (k = 0; k < need; k++) begin
        ctrl_taken[best_idx[k]] = 1'b1;
        res.control_index = gcsm_pkg::SLOT_W'(best_idx[k]);
        res.matched       = 1'b1;
        res.last          = (k == need - 1);
        assignments_due   = {assignments_due, res};
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n !== 1'b1) begin
      caliper    = gcsm_pkg::THRESHOLD_RST;
      pick_count = gcsm_pkg::MATCH_COUNT_RST;
      pool_size  = gcsm_pkg::CONTROL_COUNT_RST;
      foreach (ctrl_taken[i]) begin
        ctrl_taken[i] = 1'b0;
        ctrl_score[i] = '0;
      end
      assignments_due.delete();
    end else begin
      // result transfer against the oldest assignment due
      if (out_valid !== 1'b0) begin
        if (assignments_due.size() == 0) begin
          report_bad("result with nothing outstanding", '0, out_item);
        end else begin
          want = assignments_due.pop_front();
          if (out_item.tag_out !== want.tag_out ||
              out_item.control_index !== want.control_index ||
              out_item.matched !== want.matched ||
              out_item.last !== want.last)
            report_bad("result mismatch", want, out_item);
        end
      end
      // register writes
      if (cfg_we === 1'b1) begin
        case (cfg_index)
          gcsm_pkg::REG_THRESHOLD:     caliper    = cfg_wdata[gcsm_pkg::SCORE_W-1:0];
          gcsm_pkg::REG_MATCH_COUNT:   pick_count = cfg_wdata[gcsm_pkg::MC_W-1:0];
          gcsm_pkg::REG_CONTROL_COUNT: pool_size  = cfg_wdata[gcsm_pkg::CC_W-1:0];
          default: ;
        endcase
      end
      // command transfer
      if (start === 1'b1 && busy === 1'b0) begin
        if (in_item.opcode == gcsm_pkg::OP_LOAD) begin
          ctrl_score[in_item.slot] = in_item.score;
          ctrl_taken[in_item.slot] = 1'b0;
        end else begin
          match_case(in_item.score, in_item.case_tag);
        end
      end
    end
    awaited_results = assignments_due.size();
  end

endmodule

`default_nettype wire

// ----- test/greedy_caliper_score_matcher_tb.sv -----
// ----------------------------------------------------------------------------
// greedy_caliper_score_matcher_tb - top level test of the caliper matcher
// Directed loads and cases at the score, threshold and count extremes, then
// phases of clustered control scores with random cases and reloads. Results
// are checked by the scoreboard beside the block.
// ----------------------------------------------------------------------------
`default_nettype none

module greedy_caliper_score_matcher_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic                            clk   = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            start = 1'b0;
  logic                            busy;
  gcsm_pkg::in_item_t              in_item = '0;
  logic                            out_valid;
  gcsm_pkg::out_item_t             out_item;
  logic                            cfg_we    = 1'b0;
  logic [gcsm_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [gcsm_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
  int unsigned                     mismatch_count;
  int unsigned                     awaited_results;

  // driver bookkeeping
  bit                        loaded [gcsm_pkg::DEF_MAX_CONTROLS];
  int unsigned               loaded_prefix = 0;
  bit                        no_gaps = 1'b0;
  int unsigned               item_total, centre, thr, spread, cc_sel;
  logic [gcsm_pkg::MC_W-1:0] mc_sel;
  logic [15:0]               word;

  greedy_caliper_score_matcher u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  gcsm_match_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_item         (in_item),
    .out_valid       (out_valid),
    .out_item        (out_item),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .mismatch_count  (mismatch_count),
    .awaited_results (awaited_results)
  );

  // 100 MHz clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mostly short pauses, now and then a long one
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // score within spread of the centre, clipped to the Q0.16 range
  function automatic logic [gcsm_pkg::SCORE_W-1:0] score_near(input int unsigned ctr,
                                                              input int unsigned spr);
    int v;
    v = int'(ctr) + int'($urandom_range(0, 2 * spr)) - int'(spr);
    if (v < 0) v = 0;
    else if (v > 65535) v = 65535;
    return gcsm_pkg::SCORE_W'(v);
  endfunction

  // one command transfer; entered and left at a falling edge
  task automatic issue(input gcsm_pkg::in_item_t item);
    int unsigned gap;
    gap = no_gaps ? 0 : idle_len();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start   <= 1'b1;
    in_item <= item;
    do @(posedge clk); while (busy !== 1'b0);
    @(negedge clk);
    item_total++;
    if (item.opcode == gcsm_pkg::OP_LOAD) begin
      loaded[item.slot] = 1'b1;
      while (loaded_prefix < gcsm_pkg::DEF_MAX_CONTROLS && loaded[loaded_prefix])
        loaded_prefix++;
    end
  endtask

  task automatic load_ctrl(input logic [gcsm_pkg::SLOT_W-1:0] slot,
                           input logic [gcsm_pkg::SCORE_W-1:0] score);
    gcsm_pkg::in_item_t item;
    item.opcode   = gcsm_pkg::OP_LOAD;
    item.score    = score;
    item.slot     = slot;
    item.case_tag = gcsm_pkg::TAG_W'($urandom);
    issue(item);
  endtask

  task automatic present_case(input logic [gcsm_pkg::SCORE_W-1:0] score,
                              input logic [gcsm_pkg::TAG_W-1:0] tag);
    gcsm_pkg::in_item_t item;
    item.opcode   = gcsm_pkg::OP_CASE;
    item.score    = score;
    item.slot     = gcsm_pkg::SLOT_W'($urandom);
    item.case_tag = tag;
    issue(item);
  endtask

  // drop start, wait for every result and for busy to fall, then add a margin
  task automatic settle();
    start <= 1'b0;
    do @(negedge clk); while (awaited_results != 0 || busy !== 1'b0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [gcsm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [gcsm_pkg::CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    item_total = 0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);
    do @(negedge clk); while (busy !== 1'b0);

    // registers at reset and an empty pool: too few controls
    present_case(16'h1234, 16'h0000);
    load_ctrl(10'd0, 16'h0000);
    load_ctrl(10'd1, 16'hFFFF);
    load_ctrl(10'd2, 16'h8000);
    load_ctrl(10'd3, 16'h8000);
    load_ctrl(10'd4, 16'h8000 + 16'd6554);
    load_ctrl(10'd5, 16'h8000 - 16'd6555);
    settle();
    write_reg(gcsm_pkg::REG_CONTROL_COUNT, 16'hF806);
    // tie to the lower index, then difference at the threshold, then just past it
    present_case(16'h8000, 16'hFFFF);
    present_case(16'h8000, 16'h0001);
    present_case(16'h8000, 16'h8000);
    present_case(16'h8000, 16'h00AA);
    settle();
    // zero threshold, zero match count acting as one, reload clears taken
    write_reg(gcsm_pkg::REG_THRESHOLD, 16'h0000);
    write_reg(gcsm_pkg::REG_MATCH_COUNT, 16'hFFF0);
    load_ctrl(10'd0, 16'h0000);
    present_case(16'h0000, 16'h5555);
    present_case(16'hFFFF, 16'hAAAA);
    settle();
    // widest threshold and an oversized match count
    write_reg(gcsm_pkg::REG_THRESHOLD, 16'hFFFF);
    write_reg(gcsm_pkg::REG_MATCH_COUNT, 16'h000F);
    load_ctrl(10'd2, 16'h8000);
    load_ctrl(10'd3, 16'h8000);
    load_ctrl(10'd4, 16'h8001);
    present_case(16'h8000, 16'h0F0F);
    settle();
    write_reg(gcsm_pkg::REG_MATCH_COUNT, 16'h0003);
    present_case(16'h8000, 16'hF0F0);

    // random phases around a cluster centre
    while (item_total < 130) begin
      settle();
      case ($urandom_range(0, 6))
        0:       centre = 0;
        1:       centre = 65535;
        default: centre = $urandom_range(0, 65535);
      endcase
      case ($urandom_range(0, 9))
        0:       thr = 0;
        1:       thr = 65535;
        default: thr = $urandom_range(64, 8000);
      endcase
      mc_sel = ($urandom_range(0, 9) < 6) ? gcsm_pkg::MC_W'($urandom_range(1, 3))
                                          : gcsm_pkg::MC_W'($urandom);
      cc_sel = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 40);
      write_reg(gcsm_pkg::REG_THRESHOLD, gcsm_pkg::CFG_DATA_W'(thr));
      word = 16'($urandom);
      word[gcsm_pkg::MC_W-1:0] = mc_sel;
      write_reg(gcsm_pkg::REG_MATCH_COUNT, word);
      word = 16'($urandom);
      word[gcsm_pkg::CC_W-1:0] = gcsm_pkg::CC_W'(cc_sel);
      write_reg(gcsm_pkg::REG_CONTROL_COUNT, word);
      no_gaps = ($urandom_range(0, 3) == 0);
      spread  = thr + thr / 2 + 8;
      // every scanned entry is written before any case sees it
      while (loaded_prefix < cc_sel) begin
        load_ctrl(gcsm_pkg::SLOT_W'(loaded_prefix), score_near(centre, spread));
      end
      repeat ($urandom_range(6, 20)) begin
        if ($urandom_range(0, 9) < 7)
          present_case(score_near(centre, spread), gcsm_pkg::TAG_W'($urandom));
        else
          load_ctrl(gcsm_pkg::SLOT_W'($urandom_range(0, cc_sel + 3)),
                    score_near(centre, spread));
      end
    end

    // drain and verdict
    settle();
    repeat (20) @(negedge clk);
    if (mismatch_count == 0 && awaited_results == 0)
      $display("[greedy_caliper_score_matcher] OK");
    else
      $display("[greedy_caliper_score_matcher] ERROR");
    $finish;
  end

  // hang guard
  initial begin
    #5_000_000;
    $display("[greedy_caliper_score_matcher] ERROR");
    $finish;
  end

endmodule

`default_nettype wire
